@@ rtl/point_in_triangle_3d_defines.svh @@
// assertion macros for the point in triangle checker
`ifndef POINT_IN_TRIANGLE_3D_DEFINES_SVH
`define POINT_IN_TRIANGLE_3D_DEFINES_SVH

// same-cycle implication, sampled on clk, off while arst_n is low
`define PTRI_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("ptri_check: assertion failed");

// next-cycle implication, sampled on clk, off while arst_n is low
`define PTRI_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("ptri_check: assertion failed");

`endif

@@ rtl/ptri_pkg.sv @@
package ptri_pkg;

	typedef logic signed [16:0] d17_t;
	typedef logic signed [33:0] c34_t;

	typedef struct packed {
		logic s9;
		logic s8;
		logic s7;
		logic s6;
		logic s5;
		logic s4;
		logic s3;
		logic s2;
		logic s1;
	} pipe_en_t;

	localparam logic [15:0] TOL_RESET = 16'd1;
	localparam logic [31:0] TOL_SQ_RESET = 32'd1;

endpackage

@@ rtl/point_in_triangle_3d.sv @@
// a result passes through nine register stages, s1 to s9, after its input transfer
// one item per cycle unless stalled; each stage holds one item, moves when the next frees
// the widest step is a 34 x 34 bit multiply, in the normal length and the side products
// a new plane_tolerance is registered in tol_q, then squared into tol_sq_q before use
// arst_n low empties the pipeline and sets plane_tolerance to 1
module point_in_triangle_3d import ptri_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic [15:0]  cfg_data,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// point_x, point_y, point_z, vert_a_x..z, vert_b_x..z, vert_c_x..z
	input  logic [191:0] s_axis_tdata,
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// inside_res, zero padding
	output logic [7:0]   m_axis_tdata
);

	pipe_en_t en;

	logic        vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6, vld_s7, vld_s8, vld_s9;
	logic [15:0] tol_q;
	logic [31:0] tol_sq_q;

	logic signed [15:0] pt [3];
	logic signed [15:0] va [3];
	logic signed [15:0] vb [3];
	logic signed [15:0] vc [3];

	d17_t e1_s1 [3];
	d17_t e2_s1 [3];
	d17_t ap_s1 [3];
	d17_t a_s1 [3];
	d17_t b_s1 [3];
	d17_t c_s1 [3];
	d17_t ap_s2 [3];
	d17_t ap_s3 [3];
	c34_t n_s3 [3];
	c34_t u_s3 [3];
	c34_t v_s3 [3];
	c34_t w_s3 [3];

	logic side_ok_s5;
	logic side_s6, side_s7, side_s8, side_s9;
	logic plane_ok_s9;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tol_q    <= TOL_RESET;
			tol_sq_q <= TOL_SQ_RESET;
		end else begin
			if (cfg_valid && cfg_ready) begin
				tol_q <= cfg_data;
			end
			tol_sq_q <= 32'(tol_q) * 32'(tol_q);
		end
	end

	always_comb begin
		en.s9 = !vld_s9 || m_axis_tready;
		en.s8 = !vld_s8 || en.s9;
		en.s7 = !vld_s7 || en.s8;
		en.s6 = !vld_s6 || en.s7;
		en.s5 = !vld_s5 || en.s6;
		en.s4 = !vld_s4 || en.s5;
		en.s3 = !vld_s3 || en.s4;
		en.s2 = !vld_s2 || en.s3;
		en.s1 = !vld_s1 || en.s2;
	end

	assign s_axis_tready = en.s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
			vld_s8 <= 1'b0;
			vld_s9 <= 1'b0;
		end else begin
			if (en.s1) vld_s1 <= s_axis_tvalid;
			if (en.s2) vld_s2 <= vld_s1;
			if (en.s3) vld_s3 <= vld_s2;
			if (en.s4) vld_s4 <= vld_s3;
			if (en.s5) vld_s5 <= vld_s4;
			if (en.s6) vld_s6 <= vld_s5;
			if (en.s7) vld_s7 <= vld_s6;
			if (en.s8) vld_s8 <= vld_s7;
			if (en.s9) vld_s9 <= vld_s8;
		end
	end

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			pt[i] = s_axis_tdata[16*i +: 16];
			va[i] = s_axis_tdata[48 + 16*i +: 16];
			vb[i] = s_axis_tdata[96 + 16*i +: 16];
			vc[i] = s_axis_tdata[144 + 16*i +: 16];
		end
	end

	always_ff @(posedge clk) begin
		if (en.s1) begin
			for (int i = 0; i < 3; i++) begin
				e1_s1[i] <= 17'(vb[i]) - 17'(va[i]);
				e2_s1[i] <= 17'(vc[i]) - 17'(va[i]);
				ap_s1[i] <= 17'(pt[i]) - 17'(va[i]);
				a_s1[i]  <= 17'(va[i]) - 17'(pt[i]);
				b_s1[i]  <= 17'(vb[i]) - 17'(pt[i]);
				c_s1[i]  <= 17'(vc[i]) - 17'(pt[i]);
			end
		end
		if (en.s2) ap_s2 <= ap_s1;
		if (en.s3) ap_s3 <= ap_s2;
		if (en.s6) side_s6 <= side_ok_s5;
		if (en.s7) side_s7 <= side_s6;
		if (en.s8) side_s8 <= side_s7;
		if (en.s9) side_s9 <= side_s8;
	end

	ptri_cross u_cross_n (.clk(clk), .en(en), .p(e1_s1), .q(e2_s1), .r_s3(n_s3));
	ptri_cross u_cross_u (.clk(clk), .en(en), .p(b_s1), .q(c_s1), .r_s3(u_s3));
	ptri_cross u_cross_v (.clk(clk), .en(en), .p(c_s1), .q(a_s1), .r_s3(v_s3));
	ptri_cross u_cross_w (.clk(clk), .en(en), .p(a_s1), .q(b_s1), .r_s3(w_s3));

	ptri_side u_side (
		.clk       (clk),
		.en        (en),
		.u_s3      (u_s3),
		.v_s3      (v_s3),
		.w_s3      (w_s3),
		.side_ok_s5(side_ok_s5)
	);

	ptri_plane u_plane (
		.clk        (clk),
		.en         (en),
		.ap_s3      (ap_s3),
		.n_s3       (n_s3),
		.tol_sq     (tol_sq_q),
		.plane_ok_s9(plane_ok_s9)
	);

	assign m_axis_tvalid = vld_s9;
	assign m_axis_tdata  = {7'd0, plane_ok_s9 & side_s9};

endmodule

@@ rtl/ptri_cross.sv @@
module ptri_cross import ptri_pkg::*; (
	input  logic     clk,
	input  pipe_en_t en,
	input  d17_t     p [3],
	input  d17_t     q [3],
	output c34_t     r_s3 [3]
);

	c34_t pp_s2 [6];

	always_ff @(posedge clk) begin
		if (en.s2) begin
			pp_s2[0] <= 34'(p[1]) * 34'(q[2]);
			pp_s2[1] <= 34'(p[2]) * 34'(q[1]);
			pp_s2[2] <= 34'(p[2]) * 34'(q[0]);
			pp_s2[3] <= 34'(p[0]) * 34'(q[2]);
			pp_s2[4] <= 34'(p[0]) * 34'(q[1]);
			pp_s2[5] <= 34'(p[1]) * 34'(q[0]);
		end
	end

	always_ff @(posedge clk) begin
		if (en.s3) begin
			for (int i = 0; i < 3; i++) begin
				r_s3[i] <= pp_s2[2*i] - pp_s2[2*i+1];
			end
		end
	end

endmodule

@@ rtl/ptri_side.sv @@
module ptri_side import ptri_pkg::*; (
	input  logic     clk,
	input  pipe_en_t en,
	input  c34_t     u_s3 [3],
	input  c34_t     v_s3 [3],
	input  c34_t     w_s3 [3],
	output logic     side_ok_s5
);

	logic signed [67:0] uv_s4 [3];
	logic signed [67:0] uw_s4 [3];
	logic signed [69:0] uv_sum;
	logic signed [69:0] uw_sum;

	always_ff @(posedge clk) begin
		if (en.s4) begin
			for (int i = 0; i < 3; i++) begin
				uv_s4[i] <= 68'(u_s3[i]) * 68'(v_s3[i]);
				uw_s4[i] <= 68'(u_s3[i]) * 68'(w_s3[i]);
			end
		end
	end

	always_comb begin
		uv_sum = 70'(uv_s4[0]) + 70'(uv_s4[1]) + 70'(uv_s4[2]);
		uw_sum = 70'(uw_s4[0]) + 70'(uw_s4[1]) + 70'(uw_s4[2]);
	end

	// edge or vertex hits give zero and count as inside
	always_ff @(posedge clk) begin
		if (en.s5) begin
			side_ok_s5 <= !uv_sum[69] && !uw_sum[69];
		end
	end

endmodule

@@ rtl/ptri_plane.sv @@
module ptri_plane import ptri_pkg::*; (
	input  logic        clk,
	input  pipe_en_t    en,
	input  d17_t        ap_s3 [3],
	input  c34_t        n_s3 [3],
	input  logic [31:0] tol_sq,
	output logic        plane_ok_s9
);

	logic signed [50:0] dp_s4 [3];
	logic [65:0]        nn_s4 [3];
	logic signed [52:0] d_s5;
	logic [67:0]        nsq_s5;
	logic [51:0]        dmag_s6;
	logic [67:0]        nsq_s6;
	logic [51:0]        hh_s7;
	logic [51:0]        hl_s7;
	logic [51:0]        ll_s7;
	logic [65:0]        rl_s7;
	logic [65:0]        rh_s7;
	logic [103:0]       d2_s8;
	logic [99:0]        rhs_s8;

	always_ff @(posedge clk) begin
		if (en.s4) begin
			for (int i = 0; i < 3; i++) begin
				dp_s4[i] <= 51'(ap_s3[i]) * 51'(n_s3[i]);
				nn_s4[i] <= 66'(n_s3[i]) * 66'(n_s3[i]);
			end
		end
		if (en.s5) begin
			d_s5   <= 53'(dp_s4[0]) + 53'(dp_s4[1]) + 53'(dp_s4[2]);
			nsq_s5 <= 68'(nn_s4[0]) + 68'(nn_s4[1]) + 68'(nn_s4[2]);
		end
		if (en.s6) begin
			dmag_s6 <= d_s5[52] ? 52'(-d_s5) : 52'(d_s5);
			nsq_s6  <= nsq_s5;
		end
		// squares split into halves to keep the multipliers narrow
		if (en.s7) begin
			hh_s7 <= 52'(dmag_s6[51:26]) * 52'(dmag_s6[51:26]);
			hl_s7 <= 52'(dmag_s6[51:26]) * 52'(dmag_s6[25:0]);
			ll_s7 <= 52'(dmag_s6[25:0]) * 52'(dmag_s6[25:0]);
			rl_s7 <= 66'(nsq_s6[33:0]) * 66'(tol_sq);
			rh_s7 <= 66'(nsq_s6[67:34]) * 66'(tol_sq);
		end
		if (en.s8) begin
			d2_s8  <= (104'(hh_s7) << 52) + (104'(hl_s7) << 27) + 104'(ll_s7);
			rhs_s8 <= (100'(rh_s7) << 34) + 100'(rl_s7);
		end
		if (en.s9) begin
			plane_ok_s9 <= !(d2_s8 > 104'(rhs_s8));
		end
	end

endmodule

@@ rtl/ptri_check.sv @@
`include "point_in_triangle_3d_defines.svh"

module ptri_check (
	input logic         clk,
	input logic         arst_n,
	input logic         cfg_valid,
	input logic         cfg_ready,
	input logic         s_axis_tready,
	input logic         m_axis_tvalid,
	input logic         m_axis_tready,
	input logic [7:0]   m_axis_tdata
);

	// a stalled result transfer keeps its data
	`PTRI_ASSERT_NXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))
	// with the output stage empty every stage can move
	`PTRI_ASSERT_IMP(a_ready_empty, !m_axis_tvalid, s_axis_tready)
	`PTRI_ASSERT_IMP(a_pad_zero, m_axis_tvalid, m_axis_tdata[7:1] == 7'd0)
	`PTRI_ASSERT_IMP(a_cfg_ready, cfg_valid, cfg_ready)
	`PTRI_ASSERT_IMP(a_reset_empty, $rose(arst_n), !m_axis_tvalid)

endmodule

bind point_in_triangle_3d ptri_check u_ptri_check (.*);
